[rtl/spsrx_pkg.sv]
// Shared types, codes and coil tables for the stepper phase sequencer.
package spsrx_pkg;

  // Input word operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RX0   = 2'd1,
    OP_RX1   = 2'd2,
    OP_START = 2'd3
  } op_t;

  // Direction codes
  localparam logic [1:0] DIR_CW   = 2'd0;
  localparam logic [1:0] DIR_CCW  = 2'd1;
  localparam logic [1:0] DIR_STOP = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HALF_STEP  = 2'd0,
    CFG_STEP_LIMIT = 2'd1,
    CFG_IDLE_LIMIT = 2'd2
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic        HALF_STEP_RST  = 1'b1;
  localparam logic [15:0] STEP_LIMIT_RST = 16'd0;
  localparam logic [3:0]  IDLE_LIMIT_RST = 4'd10;
  localparam logic [3:0]  IDLE_SAT       = 4'd15;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [1:0] run_direction;
  } in_word_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       coils_on;
    logic       limit_reached;
    logic [1:0] current_direction;
    logic       frame_ready;
    logic       second_rx_seen;
    logic [7:0] first_fill;
    logic [7:0] second_fill;
  } out_word_t;

  // Coil tables, indexed by phase
  localparam logic [3:0] HALF_CCW [8] = '{4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8};
  localparam logic [3:0] HALF_CW  [8] = '{4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};
  localparam logic [3:0] FULL_CCW [4] = '{4'he, 4'hd, 4'hb, 4'h7};
  localparam logic [3:0] FULL_CW  [4] = '{4'he, 4'h7, 4'hb, 4'hd};

  // Coil pattern for a running direction (cw when ccw is low)
  function automatic logic [3:0] coil_lookup(input logic ccw, input logic half,
                                             input logic [2:0] phase);
    logic [3:0] pat;
    if (half) begin
      pat = ccw ? HALF_CCW[phase] : HALF_CW[phase];
    end else begin
      pat = ccw ? FULL_CCW[phase[1:0]] : FULL_CW[phase[1:0]];
    end
    return pat;
  endfunction

endpackage

[rtl/stepper_phase_sequencer_with_rx_idle.sv]
// Stepper phase sequencer with two receive buffers and an idle frame timer.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_data   (in_word_t)
//   out_     output     out_valid/out_stall out_data (out_word_t)
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per clock: every input word updates the state in the cycle it is
// accepted and its result word is registered, visible the next cycle.
// Input is stalled only while a result word is held by out_stall.
// rst_n is synchronous; it clears control state and loads config defaults.
// Receive buffers need no clearing; their contents are write-only storage.
module stepper_phase_sequencer_with_rx_idle
  import spsrx_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  // Configuration registers
  logic        half_step_r;
  logic [15:0] step_limit_r;
  logic [3:0]  idle_limit_r;

  // Sequencer and receive state
  logic [2:0]    phase_r, phase_nxt;
  logic [16:0]   tick_cnt_r, tick_cnt_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic          done_r, done_nxt;
  logic [3:0]    drive_bits_r, drive_bits_nxt;
  logic          drive_en_r, drive_en_nxt;
  logic [3:0]    idle_r, idle_nxt;
  logic          frame_r, frame_nxt;
  logic          second_r, second_nxt;
  logic [CW-1:0] first_cnt_r, first_cnt_nxt;
  logic [CW-1:0] second_cnt_r, second_cnt_nxt;

  logic [7:0] first_buf  [BUFFER_DEPTH];
  logic [7:0] second_buf [BUFFER_DEPTH];

  logic          out_valid_r;
  out_word_t     out_data_r, out_data_nxt;
  logic          in_acc;
  logic          first_wr, second_wr;
  logic [2:0]    phase_inc;
  logic [3:0]    idle_inc;
  logic [CW+7:0] first_ext, second_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign first_wr  = in_acc && (in_data.operation == OP_RX0) && (first_cnt_r < DEPTH_C);
  assign second_wr = in_acc && (in_data.operation == OP_RX1) && (second_cnt_r < DEPTH_C);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_step_r  <= HALF_STEP_RST;
      step_limit_r <= STEP_LIMIT_RST;
      idle_limit_r <= IDLE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_STEP:  half_step_r  <= cfg_data[0];
        CFG_STEP_LIMIT: step_limit_r <= cfg_data[15:0];
        CFG_IDLE_LIMIT: idle_limit_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Next state for one input word
  always_comb begin
    phase_nxt      = phase_r;
    tick_cnt_nxt   = tick_cnt_r;
    dir_nxt        = dir_r;
    done_nxt       = done_r;
    drive_bits_nxt = drive_bits_r;
    drive_en_nxt   = drive_en_r;
    idle_nxt       = idle_r;
    frame_nxt      = frame_r;
    second_nxt     = second_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    phase_inc      = 3'd0;
    idle_inc       = 4'd0;

    unique case (in_data.operation)
      OP_TICK: begin
        // coil drive from the state before this tick
        if (dir_r == DIR_CW || dir_r == DIR_CCW) begin
          drive_bits_nxt = coil_lookup(dir_r == DIR_CCW, half_step_r, phase_r);
          drive_en_nxt   = 1'b1;
        end else begin
          drive_bits_nxt = 4'd0;
          drive_en_nxt   = 1'b0;
        end
        // step count and limit stop
        if (tick_cnt_r <= {1'b0, step_limit_r}) begin
          tick_cnt_nxt = tick_cnt_r + 17'd1;
          phase_inc    = phase_r + 3'd1;
        end else begin
          dir_nxt      = DIR_STOP;
          done_nxt     = 1'b1;
          tick_cnt_nxt = 17'd0;
          phase_inc    = 3'd1;
        end
        // phase wrap at the step mode
        if (!half_step_r && phase_inc[2]) begin
          phase_nxt = 3'd0;
        end else begin
          phase_nxt = phase_inc;
        end
        // idle timer, saturating
        idle_inc = (idle_r < IDLE_SAT) ? idle_r + 4'd1 : idle_r;
        if (idle_inc >= idle_limit_r) begin
          idle_nxt      = 4'd0;
          frame_nxt     = 1'b1;
          first_cnt_nxt = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end
      OP_RX0: begin
        if (first_cnt_r < DEPTH_C) first_cnt_nxt = first_cnt_r + CW'(1);
        idle_nxt = 4'd0;
      end
      OP_RX1: begin
        if (second_cnt_r < DEPTH_C) second_cnt_nxt = second_cnt_r + CW'(1);
        idle_nxt   = 4'd0;
        second_nxt = 1'b1;
      end
      OP_START: begin
        dir_nxt = (in_data.run_direction > DIR_STOP) ? DIR_STOP : in_data.run_direction;
      end
      default: ;
    endcase
  end

  // Result word from the next state
  assign first_ext  = {8'd0, first_cnt_nxt};
  assign second_ext = {8'd0, second_cnt_nxt};

  always_comb begin
    out_data_nxt.coil_pattern      = drive_bits_nxt;
    out_data_nxt.coils_on          = drive_en_nxt;
    out_data_nxt.limit_reached     = done_nxt;
    out_data_nxt.current_direction = dir_nxt;
    out_data_nxt.frame_ready       = frame_nxt;
    out_data_nxt.second_rx_seen    = second_nxt;
    out_data_nxt.first_fill        = first_ext[7:0];
    out_data_nxt.second_fill       = second_ext[7:0];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 3'd0;
      tick_cnt_r   <= 17'd0;
      dir_r        <= DIR_STOP;
      done_r       <= 1'b0;
      drive_bits_r <= 4'd0;
      drive_en_r   <= 1'b0;
      idle_r       <= 4'd0;
      frame_r      <= 1'b0;
      second_r     <= 1'b0;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      dir_r        <= dir_nxt;
      done_r       <= done_nxt;
      drive_bits_r <= drive_bits_nxt;
      drive_en_r   <= drive_en_nxt;
      idle_r       <= idle_nxt;
      frame_r      <= frame_nxt;
      second_r     <= second_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
    end
  end

  // Receive buffers
  always_ff @(posedge clk) begin
    if (first_wr) first_buf[first_cnt_r[AW-1:0]] <= in_data.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (second_wr) second_buf[second_cnt_r[AW-1:0]] <= in_data.rx_byte;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= out_data_nxt;
  end

endmodule

[verif/tb_stepper_phase_sequencer_with_rx_idle.sv]
// Self-checking testbench for the stepper phase sequencer with receive idle timer.
module tb_stepper_phase_sequencer_with_rx_idle
  import spsrx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_DEPTH  = 128;
  localparam int QUIET_MAX  = 3000;
  localparam int NUM_PHASES = 11;
  localparam int IN_W       = $bits(in_word_t);

  // Coil sequences, entry 0 in the low nibble
  localparam logic [31:0] HALF_CW_SEQ  = 32'h9132_64c8;
  localparam logic [31:0] HALF_CCW_SEQ = 32'h8c46_2319;
  localparam logic [15:0] FULL_CW_SEQ  = 16'hdb7e;
  localparam logic [15:0] FULL_CCW_SEQ = 16'h7bde;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow registers and sequencer state
  logic        half_mode;
  logic [15:0] step_max;
  logic [3:0]  idle_max;
  logic [2:0]  phase_pos;
  logic [16:0] steps_taken;
  logic [1:0]  dir_now;
  logic        done_seen;
  logic [3:0]  coil_bits;
  logic        coil_enable;
  logic [3:0]  quiet_ticks;
  logic        frame_seen;
  logic        ch1_seen;
  logic [7:0]  fill0;
  logic [7:0]  fill1;

  in_word_t  pending_words[$];
  out_word_t due_status[$];

  int send_gap_pct;
  int recv_stall_pct;
  int err_count;
  int quiet_cycles;

  stepper_phase_sequencer_with_rx_idle #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Apply one input word to the shadow state and return the status it produces
  function automatic out_word_t step_sequencer(in_word_t w);
    out_word_t r;
    case (op_t'(w.operation))
      OP_TICK: begin
        if (dir_now == DIR_CW || dir_now == DIR_CCW) begin
          if (half_mode) begin
            coil_bits = (dir_now == DIR_CW) ? HALF_CW_SEQ[4*phase_pos +: 4]
                                            : HALF_CCW_SEQ[4*phase_pos +: 4];
          end else begin
            coil_bits = (dir_now == DIR_CW) ? FULL_CW_SEQ[4*phase_pos[1:0] +: 4]
                                            : FULL_CCW_SEQ[4*phase_pos[1:0] +: 4];
          end
          coil_enable = 1'b1;
        end else begin
          coil_bits   = 4'd0;
          coil_enable = 1'b0;
        end
        // step limit passed: stop and latch done
        if (steps_taken <= {1'b0, step_max}) begin
          steps_taken = steps_taken + 17'd1;
        end else begin
          dir_now     = DIR_STOP;
          done_seen   = 1'b1;
          steps_taken = '0;
          phase_pos   = '0;
        end
        phase_pos = phase_pos + 3'd1;
        if (!half_mode && phase_pos >= 3'd4) begin
          phase_pos = '0;
        end
        // idle timer saturates; timeout flags frame end and rewinds channel 0
        if (quiet_ticks != IDLE_SAT) begin
          quiet_ticks = quiet_ticks + 4'd1;
        end
        if (quiet_ticks >= idle_max) begin
          quiet_ticks = '0;
          frame_seen  = 1'b1;
          fill0       = '0;
        end
      end
      OP_RX0: begin
        if (fill0 < BUF_DEPTH) begin
          fill0 = fill0 + 8'd1;
        end
        quiet_ticks = '0;
      end
      OP_RX1: begin
        if (fill1 < BUF_DEPTH) begin
          fill1 = fill1 + 8'd1;
        end
        quiet_ticks = '0;
        ch1_seen    = 1'b1;
      end
      OP_START: begin
        dir_now = (w.run_direction > DIR_STOP) ? DIR_STOP : w.run_direction;
      end
    endcase
    r.coil_pattern      = coil_bits;
    r.coils_on          = coil_enable;
    r.limit_reached     = done_seen;
    r.current_direction = dir_now;
    r.frame_ready       = frame_seen;
    r.second_rx_seen    = ch1_seen;
    r.first_fill        = fill0;
    r.second_fill       = fill1;
    return r;
  endfunction

  function automatic string status_text(out_word_t s);
    return $sformatf("pat=%h on=%b done=%b dir=%0d frame=%b rx1=%b fill0=%0d fill1=%0d",
                     s.coil_pattern, s.coils_on, s.limit_reached, s.current_direction,
                     s.frame_ready, s.second_rx_seen, s.first_fill, s.second_fill);
  endfunction

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR %0t: %s", $realtime, msg);
    end
  endtask

  // Input word driver
  always @(posedge clk) begin : drive_words
    in_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_status.push_back(step_sequencer(in_data));
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = pending_words.pop_front();
        in_valid <= 1'b1;
        in_data  <= nxt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Status word monitor and receiver stall
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_status.size() == 0) begin
          note_error($sformatf("unexpected status word: %s", status_text(out_data)));
        end else begin
          want = due_status.pop_front();
          if (out_data.coil_pattern !== want.coil_pattern ||
              out_data.coils_on !== want.coils_on ||
              out_data.limit_reached !== want.limit_reached ||
              out_data.current_direction !== want.current_direction ||
              out_data.frame_ready !== want.frame_ready ||
              out_data.second_rx_seen !== want.second_rx_seen ||
              out_data.first_fill !== want.first_fill ||
              out_data.second_fill !== want.second_fill) begin
            note_error($sformatf("status mismatch: expected %s, got %s",
                                 status_text(want), status_text(out_data)));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("stepper_phase_sequencer_with_rx_idle regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HALF_STEP:  half_mode = val[0];
      CFG_STEP_LIMIT: step_max  = val;
      CFG_IDLE_LIMIT: idle_max  = val[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || due_status.size() != 0);
  endtask

  task automatic push_tick();
    in_word_t w;
    w.operation     = OP_TICK;
    w.rx_byte       = 8'($urandom);
    w.run_direction = 2'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic push_rx(op_t ch, logic [7:0] b);
    in_word_t w;
    w.operation     = ch;
    w.rx_byte       = b;
    w.run_direction = 2'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic push_start(logic [1:0] d);
    in_word_t w;
    w.operation     = OP_START;
    w.rx_byte       = 8'($urandom);
    w.run_direction = d;
    pending_words.push_back(w);
  endtask

  // Mostly motor runs and receive bursts with random content, some raw noise
  task automatic queue_mixed(int n_words, bit long_burst);
    int kind;
    logic [1:0] d;
    logic [IN_W-1:0] raw;
    if (long_burst) begin
      repeat (BUF_DEPTH + 4) push_rx(OP_RX0, 8'($urandom));
    end
    while (pending_words.size() < n_words) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        d = 2'($urandom_range(1));
        if ($urandom_range(9) == 0) begin
          d = 2'($urandom_range(3));
        end
        push_start(d);
        repeat ($urandom_range(24, 1)) begin
          if ($urandom_range(5) == 0) begin
            push_rx($urandom_range(1) ? OP_RX1 : OP_RX0, 8'($urandom));
          end
          push_tick();
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(8, 1)) push_rx($urandom_range(1) ? OP_RX1 : OP_RX0,
                                              8'($urandom));
        repeat ($urandom_range(16)) push_tick();
      end else begin
        raw = IN_W'($urandom);
        pending_words.push_back(raw);
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_HALF_STEP;
    cfg_data       = '0;
    err_count      = 0;
    quiet_cycles   = 0;
    send_gap_pct   = 33;
    recv_stall_pct = 66;

    half_mode   = HALF_STEP_RST;
    step_max    = STEP_LIMIT_RST;
    idle_max    = IDLE_LIMIT_RST;
    phase_pos   = '0;
    steps_taken = '0;
    dir_now     = DIR_STOP;
    done_seen   = 1'b0;
    coil_bits   = '0;
    coil_enable = 1'b0;
    quiet_ticks = '0;
    frame_seen  = 1'b0;
    ch1_seen    = 1'b0;
    fill0       = '0;
    fill1       = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: coils off when stopped, step limit zero stops on second tick
    push_tick();
    push_start(DIR_CW);
    push_tick();
    push_tick();
    push_start(2'd3);
    push_start(DIR_CCW);
    push_tick();
    push_rx(OP_RX0, 8'h00);
    push_rx(OP_RX0, 8'hff);
    push_rx(OP_RX1, 8'ha5);
    wait_drained();

    // Full step, widest step limit, idle limit zero
    write_reg(CFG_HALF_STEP, 16'd0);
    write_reg(CFG_STEP_LIMIT, 16'hffff);
    write_reg(CFG_IDLE_LIMIT, 16'd0);
    push_start(DIR_CW);
    push_tick();
    push_tick();
    push_start(DIR_CCW);
    push_tick();
    push_tick();
    push_rx(OP_RX1, 8'h5a);
    push_start(DIR_STOP);
    push_tick();
    wait_drained();

    // Mode switched mid-run with the phase past the full-step range
    write_reg(CFG_HALF_STEP, 16'd1);
    write_reg(CFG_IDLE_LIMIT, 16'd15);
    push_start(DIR_CW);
    repeat (5) push_tick();
    wait_drained();
    write_reg(CFG_HALF_STEP, 16'd0);
    push_tick();
    push_tick();
    wait_drained();

    // Random phases across register settings and idling mixes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        send_gap_pct   = 33;
        recv_stall_pct = 66;
      end else if (ph < 8) begin
        send_gap_pct   = 66;
        recv_stall_pct = 33;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if (ph == 0) begin
        write_reg(CFG_HALF_STEP, 16'd1);
        write_reg(CFG_STEP_LIMIT, 16'd0);
        write_reg(CFG_IDLE_LIMIT, 16'd1);
      end else if (ph == 1) begin
        write_reg(CFG_HALF_STEP, 16'd0);
        write_reg(CFG_STEP_LIMIT, 16'hffff);
        write_reg(CFG_IDLE_LIMIT, 16'd15);
      end else begin
        write_reg(CFG_HALF_STEP, 16'($urandom_range(1)));
        write_reg(CFG_STEP_LIMIT, 16'(($urandom_range(4) == 0) ? $urandom_range(16'hffff)
                                                               : $urandom_range(40)));
        write_reg(CFG_IDLE_LIMIT, 16'($urandom_range(15)));
      end
      queue_mixed(110, (ph == 2) || ($urandom_range(3) == 0));
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (due_status.size() != 0) begin
      note_error($sformatf("%0d status words never arrived", due_status.size()));
    end
    if (err_count == 0) begin
      $display("stepper_phase_sequencer_with_rx_idle regression: pass");
    end else begin
      $display("stepper_phase_sequencer_with_rx_idle regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/spsrx_pkg.sv
rtl/stepper_phase_sequencer_with_rx_idle.sv
verif/tb_stepper_phase_sequencer_with_rx_idle.sv
